@@ hdl/btwu_pkg.sv @@
// Shared types and constants of the brake thermal and wear update block.
package btwu_pkg;

  // Fixed-point reference values
  localparam logic [15:0]        ONE_Q15          = 16'h8000;
  localparam logic [31:0]        WEAR_ONE         = 32'h8000_0000;
  localparam logic signed [23:0] TEMP_MAX         = 24'sd524287;
  localparam logic signed [23:0] TEMP_MIN         = -24'sd524288;
  localparam logic signed [15:0] AMBIENT_MIN      = -16'sd4370;
  localparam logic [22:0]        TEMP_STEP_CAP    = 23'h40_0000;
  localparam logic [15:0]        WEAR_LOSS_AT_END = 16'd16384;

  // Request opcodes
  localparam logic OP_STEP   = 1'b0;
  localparam logic OP_REINIT = 1'b1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_FRACTION     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLING_COEFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_THERMAL_MASS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WEAR_CAPACITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_TEMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_START_TEMP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_INV_SPAN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FADE_FACTOR   = 3'd7;

  // Register values after reset
  localparam logic [15:0] RST_HEAT_FRACTION     = 16'd32768;
  localparam logic [23:0] RST_COOLING_COEFF     = 24'd2560;
  localparam logic [31:0] RST_INV_THERMAL_MASS  = 32'd1073742;
  localparam logic [39:0] RST_INV_WEAR_CAPACITY = 40'd28147498;
  localparam logic [15:0] RST_AMBIENT_TEMP      = 16'd320;
  localparam logic [16:0] RST_FADE_START_TEMP   = 17'd6400;
  localparam logic [31:0] RST_FADE_INV_SPAN     = 32'd5243;
  localparam logic [15:0] RST_MIN_FADE_FACTOR   = 16'd16384;

  // Configuration register set (signed fields kept as raw bits)
  typedef struct packed {
    logic [15:0] heat_fraction;
    logic [23:0] cooling_coeff;
    logic [31:0] inv_thermal_mass;
    logic [39:0] inv_wear_capacity;
    logic [15:0] ambient_temp;
    logic [16:0] fade_start_temp;
    logic [31:0] fade_inv_span;
    logic [15:0] min_fade_factor;
  } cfg_t;

endpackage

@@ hdl/brake_thermal_wear_update_top.sv @@
// Top level of the brake thermal and wear update block: sequencer around one shared multiplier.
//
// One request is handled at a time by a sequencer that drives a single registered 32x32
// multiplier, one product per cycle. An update step runs a chain of twelve products through
// the one multiplier into the result register, and the block accepts again once it is back
// in idle. A reinitialise request runs only the fade products for the thermal and available
// factors, or goes straight to the result with an invalid configuration, as does a rejected
// step (zero time step or invalid configuration). A finished result waits in the output
// register while the next request is accepted; the sequencer only holds in its last state if
// that register is still occupied. Configuration writes take effect at once and must only be
// made while the block is idle.
module brake_thermal_wear_update_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [btwu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [btwu_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [15:0]                         brake_torque_i,
  input  logic [15:0]                         angular_speed_i,
  input  logic [15:0]                         time_step_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                valid_res_o,
  output logic [31:0]                         friction_power_o,
  output logic [31:0]                         heat_power_o,
  output logic [31:0]                         cooling_power_o,
  output logic [39:0]                         heat_energy_o,
  output logic [15:0]                         thermal_factor_o,
  output logic [15:0]                         wear_factor_o,
  output logic [15:0]                         available_factor_o,
  output logic signed [19:0]                  temperature_now_o,
  output logic [31:0]                         wear_now_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_FP,
    S_HP,
    S_CP,
    S_HE,
    S_MAG,
    S_D0,
    S_D1,
    S_W0,
    S_W1,
    S_W2,
    S_ALPHA,
    S_TF0,
    S_TF1,
    S_AF0,
    S_AF1,
    S_DONE
  } state_e;

  btwu_pkg::cfg_t cfg_q;
  logic           cfg_ok;

  state_e         state_q;
  logic [15:0]    torque_q, speed_q, ts_q;

  // shared multiplier
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    mul_q;

  // working registers
  logic [31:0]        fp_q, hp_q, cp_q, he_q;
  logic [47:0]        mag_q;
  logic [31:0]        lo_q;
  logic [6:0]         frac_q;
  logic [48:0]        dsum_q;
  logic               cool_wins_q;
  logic [31:0]        inc_q;
  logic signed [19:0] temp_q;
  logic [31:0]        wear_q;
  logic               tle_q, big_q;
  logic [15:0]        tf_q, wf_q, af_q;
  logic               res_ok_q, reject_q;

  // output register
  logic               out_valid_q;
  logic               valid_res_q;
  logic [31:0]        friction_power_q, heat_power_q, cooling_power_q;
  logic [39:0]        heat_energy_q;
  logic [15:0]        thermal_factor_q, wear_factor_q, available_factor_q;
  logic signed [19:0] temperature_now_q;
  logic [31:0]        wear_now_q;

  // helper values
  logic signed [15:0] amb_s;
  logic signed [23:0] amb24, temp24, nt_raw, nt_floor, nt_new;
  logic signed [20:0] excess_full, fade_diff;
  logic [19:0]        excess;
  logic               fade_le;
  logic               cool_wins_c;
  logic [31:0]        net_diff;
  logic [28:0]        d_full;
  logic [22:0]        d_cap;
  logic [40:0]        inc_sum;
  logic [31:0]        inc_c;
  logic [32:0]        wear_sum;
  logic [47:0]        wear_loss;
  logic [15:0]        wf_c;
  logic [15:0]        fade_gap;

  // ---------------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heat_fraction     <= btwu_pkg::RST_HEAT_FRACTION;
      cfg_q.cooling_coeff     <= btwu_pkg::RST_COOLING_COEFF;
      cfg_q.inv_thermal_mass  <= btwu_pkg::RST_INV_THERMAL_MASS;
      cfg_q.inv_wear_capacity <= btwu_pkg::RST_INV_WEAR_CAPACITY;
      cfg_q.ambient_temp      <= btwu_pkg::RST_AMBIENT_TEMP;
      cfg_q.fade_start_temp   <= btwu_pkg::RST_FADE_START_TEMP;
      cfg_q.fade_inv_span     <= btwu_pkg::RST_FADE_INV_SPAN;
      cfg_q.min_fade_factor   <= btwu_pkg::RST_MIN_FADE_FACTOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btwu_pkg::CFG_HEAT_FRACTION:     cfg_q.heat_fraction     <= cfg_wdata_i[15:0];
        btwu_pkg::CFG_COOLING_COEFF:     cfg_q.cooling_coeff     <= cfg_wdata_i[23:0];
        btwu_pkg::CFG_INV_THERMAL_MASS:  cfg_q.inv_thermal_mass  <= cfg_wdata_i[31:0];
        btwu_pkg::CFG_INV_WEAR_CAPACITY: cfg_q.inv_wear_capacity <= cfg_wdata_i[39:0];
        btwu_pkg::CFG_AMBIENT_TEMP:      cfg_q.ambient_temp      <= cfg_wdata_i[15:0];
        btwu_pkg::CFG_FADE_START_TEMP:   cfg_q.fade_start_temp   <= cfg_wdata_i[16:0];
        btwu_pkg::CFG_FADE_INV_SPAN:     cfg_q.fade_inv_span     <= cfg_wdata_i[31:0];
        btwu_pkg::CFG_MIN_FADE_FACTOR:   cfg_q.min_fade_factor   <= cfg_wdata_i[15:0];
      endcase
    end
  end

  // configuration validity
  assign amb_s  = $signed(cfg_q.ambient_temp);
  assign cfg_ok = (cfg_q.inv_thermal_mass != 32'd0)
               && (cfg_q.inv_wear_capacity != 40'd0)
               && (cfg_q.fade_inv_span != 32'd0)
               && (amb_s >= btwu_pkg::AMBIENT_MIN)
               && (cfg_q.heat_fraction <= btwu_pkg::ONE_Q15)
               && (cfg_q.min_fade_factor <= btwu_pkg::ONE_Q15)
               && (btwu_pkg::WEAR_LOSS_AT_END <= btwu_pkg::ONE_Q15);

  // ---------------------------------------------------------------------------
  // datapath helpers
  assign amb24  = {{8{amb_s[15]}}, amb_s};
  assign temp24 = {{4{temp_q[19]}}, temp_q};

  // temperature above ambient, floored at zero
  assign excess_full = {temp_q[19], temp_q} - {{5{amb_s[15]}}, amb_s};
  assign excess      = excess_full[20] ? 20'd0 : excess_full[19:0];

  // net heat magnitude and direction
  assign cool_wins_c = (hp_q < cp_q);
  assign net_diff    = cool_wins_c ? (cp_q - hp_q) : (hp_q - cp_q);

  // temperature change, saturated at 2^22
  assign d_full = dsum_q[48:20];
  assign d_cap  = (d_full > {6'd0, btwu_pkg::TEMP_STEP_CAP}) ? btwu_pkg::TEMP_STEP_CAP
                                                              : d_full[22:0];
  assign nt_raw   = cool_wins_q ? (temp24 - {1'b0, d_cap}) : (temp24 + {1'b0, d_cap});
  assign nt_floor = (nt_raw < amb24) ? amb24 : nt_raw;
  always_comb begin
    nt_new = nt_floor;
    if (nt_floor > btwu_pkg::TEMP_MAX) begin
      nt_new = btwu_pkg::TEMP_MAX;
    end else if (nt_floor < btwu_pkg::TEMP_MIN) begin
      nt_new = btwu_pkg::TEMP_MIN;
    end
  end

  // wear increment from the two partial products, saturated at one
  assign inc_sum = {1'b0, mul_q[39:0]} + {9'd0, lo_q};
  assign inc_c   = (|inc_sum[40:24]) ? btwu_pkg::WEAR_ONE : {1'b0, inc_sum[23:0], frac_q};
  assign wear_sum = {1'b0, wear_q} + {1'b0, inc_q};

  // fade ramp input
  assign fade_diff = {temp_q[19], temp_q}
                   - {{4{cfg_q.fade_start_temp[16]}}, cfg_q.fade_start_temp};
  assign fade_le   = fade_diff[20] || (fade_diff == 21'sd0);
  assign fade_gap  = btwu_pkg::ONE_Q15 - cfg_q.min_fade_factor;

  // wear factor: constant loss times clamped wear
  assign wear_loss = {32'd0, btwu_pkg::WEAR_LOSS_AT_END} * {16'd0, wear_q};
  assign wf_c      = btwu_pkg::ONE_Q15 - wear_loss[46:31];

  // ---------------------------------------------------------------------------
  // multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      S_FP: begin
        mul_a = {16'd0, torque_q};
        mul_b = {16'd0, speed_q};
      end
      S_HP: begin
        mul_a = mul_q[31:0];
        mul_b = {16'd0, cfg_q.heat_fraction};
      end
      S_CP: begin
        mul_a = {12'd0, excess};
        mul_b = {8'd0, cfg_q.cooling_coeff};
      end
      S_HE: begin
        mul_a = hp_q;
        mul_b = {16'd0, ts_q};
      end
      S_MAG: begin
        mul_a = net_diff;
        mul_b = {16'd0, ts_q};
      end
      S_D0: begin
        mul_a = mul_q[31:0];
        mul_b = cfg_q.inv_thermal_mass;
      end
      S_D1: begin
        mul_a = {16'd0, mag_q[47:32]};
        mul_b = cfg_q.inv_thermal_mass;
      end
      S_W0: begin
        mul_a = he_q;
        mul_b = cfg_q.inv_wear_capacity[31:0];
      end
      S_W1: begin
        mul_a = he_q;
        mul_b = {24'd0, cfg_q.inv_wear_capacity[39:32]};
      end
      S_ALPHA: begin
        mul_a = {12'd0, fade_diff[19:0]};
        mul_b = cfg_q.fade_inv_span;
      end
      S_TF0: begin
        mul_a = {16'd0, fade_gap};
        mul_b = {8'd0, mul_q[23:0]};
      end
      S_AF0: begin
        mul_a = {16'd0, tf_q};
        mul_b = {16'd0, wf_c};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      torque_q           <= 16'd0;
      speed_q            <= 16'd0;
      ts_q               <= 16'd0;
      fp_q               <= 32'd0;
      hp_q               <= 32'd0;
      cp_q               <= 32'd0;
      he_q               <= 32'd0;
      mag_q              <= 48'd0;
      lo_q               <= 32'd0;
      frac_q             <= 7'd0;
      dsum_q             <= 49'd0;
      cool_wins_q        <= 1'b0;
      inc_q              <= 32'd0;
      temp_q             <= {{4{btwu_pkg::RST_AMBIENT_TEMP[15]}}, btwu_pkg::RST_AMBIENT_TEMP};
      wear_q             <= 32'd0;
      tle_q              <= 1'b0;
      big_q              <= 1'b0;
      tf_q               <= 16'd0;
      wf_q               <= 16'd0;
      af_q               <= 16'd0;
      res_ok_q           <= 1'b0;
      reject_q           <= 1'b0;
      out_valid_q        <= 1'b0;
      valid_res_q        <= 1'b0;
      friction_power_q   <= 32'd0;
      heat_power_q       <= 32'd0;
      cooling_power_q    <= 32'd0;
      heat_energy_q      <= 40'd0;
      thermal_factor_q   <= 16'd0;
      wear_factor_q      <= 16'd0;
      available_factor_q <= 16'd0;
      temperature_now_q  <= 20'sd0;
      wear_now_q         <= 32'd0;
    end else begin
      // result taken downstream; in the last state the reload below handles it
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            torque_q <= brake_torque_i;
            speed_q  <= angular_speed_i;
            ts_q     <= time_step_i;
            fp_q     <= 32'd0;
            hp_q     <= 32'd0;
            cp_q     <= 32'd0;
            he_q     <= 32'd0;
            tf_q     <= 16'd0;
            wf_q     <= 16'd0;
            af_q     <= 16'd0;
            if (opcode_i == btwu_pkg::OP_REINIT) begin
              res_ok_q <= cfg_ok;
              reject_q <= 1'b0;
              temp_q   <= {{4{amb_s[15]}}, amb_s};
              wear_q   <= 32'd0;
              inc_q    <= 32'd0;
              state_q  <= cfg_ok ? S_ALPHA : S_DONE;
            end else if (!cfg_ok || (time_step_i == 16'd0)) begin
              // rejected step: all fields zero, state kept
              res_ok_q <= 1'b0;
              reject_q <= 1'b1;
              state_q  <= S_DONE;
            end else begin
              res_ok_q <= 1'b1;
              reject_q <= 1'b0;
              state_q  <= S_FP;
            end
          end
        end
        S_FP: begin
          state_q <= S_HP;
        end
        S_HP: begin
          fp_q    <= mul_q[31:0];
          state_q <= S_CP;
        end
        S_CP: begin
          hp_q    <= mul_q[46:15];
          state_q <= S_HE;
        end
        S_HE: begin
          // cooling power saturates at 32 bits
          cp_q    <= (|mul_q[63:36]) ? 32'hFFFF_FFFF : mul_q[35:4];
          state_q <= S_MAG;
        end
        S_MAG: begin
          he_q        <= mul_q[47:16];
          cool_wins_q <= cool_wins_c;
          state_q     <= S_D0;
        end
        S_D0: begin
          mag_q   <= mul_q[47:0];
          state_q <= S_D1;
        end
        S_D1: begin
          lo_q    <= mul_q[63:32];
          state_q <= S_W0;
        end
        S_W0: begin
          dsum_q  <= {1'b0, mul_q[47:0]} + {17'd0, lo_q};
          state_q <= S_W1;
        end
        S_W1: begin
          lo_q    <= mul_q[63:32];
          frac_q  <= mul_q[31:25];
          temp_q  <= nt_new[19:0];
          state_q <= S_W2;
        end
        S_W2: begin
          inc_q   <= inc_c;
          state_q <= S_ALPHA;
        end
        S_ALPHA: begin
          // wear accumulates, clamped to one
          wear_q  <= (wear_sum > {1'b0, btwu_pkg::WEAR_ONE}) ? btwu_pkg::WEAR_ONE
                                                             : wear_sum[31:0];
          tle_q   <= fade_le;
          state_q <= S_TF0;
        end
        S_TF0: begin
          big_q   <= |mul_q[63:24];
          state_q <= S_TF1;
        end
        S_TF1: begin
          if (tle_q) begin
            tf_q <= btwu_pkg::ONE_Q15;
          end else if (big_q) begin
            tf_q <= cfg_q.min_fade_factor;
          end else begin
            tf_q <= btwu_pkg::ONE_Q15 - mul_q[39:24];
          end
          state_q <= S_AF0;
        end
        S_AF0: begin
          wf_q    <= wf_c;
          state_q <= S_AF1;
        end
        S_AF1: begin
          af_q    <= (mul_q[63:15] > {33'd0, btwu_pkg::ONE_Q15}) ? btwu_pkg::ONE_Q15
                                                                  : mul_q[30:15];
          state_q <= S_DONE;
        end
        S_DONE: begin
          // load the output register once it is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q        <= 1'b1;
            valid_res_q        <= res_ok_q;
            friction_power_q   <= fp_q;
            heat_power_q       <= hp_q;
            cooling_power_q    <= cp_q;
            heat_energy_q      <= {8'd0, he_q};
            thermal_factor_q   <= tf_q;
            wear_factor_q      <= wf_q;
            available_factor_q <= af_q;
            temperature_now_q  <= reject_q ? 20'sd0 : temp_q;
            wear_now_q         <= reject_q ? 32'd0 : wear_q;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // ports
  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign valid_res_o        = valid_res_q;
  assign friction_power_o   = friction_power_q;
  assign heat_power_o       = heat_power_q;
  assign cooling_power_o    = cooling_power_q;
  assign heat_energy_o      = heat_energy_q;
  assign thermal_factor_o   = thermal_factor_q;
  assign wear_factor_o      = wear_factor_q;
  assign available_factor_o = available_factor_q;
  assign temperature_now_o  = temperature_now_q;
  assign wear_now_o         = wear_now_q;

endmodule
